// File: rtl/sdlt_pkg.sv
// ----------------------------------------------------------------------------
// sdlt_pkg
// Shared types and constants for the session/device link table.
// ----------------------------------------------------------------------------
package sdlt_pkg;

  // Input selector values
  localparam logic [1:0] FUNC_MSG   = 2'd0;
  localparam logic [1:0] FUNC_CLOSE = 2'd1;
  localparam logic [1:0] FUNC_PKT   = 2'd2;

  // Command byte values
  localparam logic [7:0] CMD_SCAN = 8'd0;
  localparam logic [7:0] CMD_LINK = 8'd1;
  localparam logic [7:0] CMD_SEND = 8'd2;

  // Reply codes
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_ACK     = 3'd1;
  localparam logic [2:0] RC_INVALID = 3'd2;
  localparam logic [2:0] RC_ERROR   = 3'd3;
  localparam logic [2:0] RC_UNKNOWN = 3'd4;

  // Actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_SCAN    = 2'd1;
  localparam logic [1:0] ACT_FORWARD = 2'd2;

  // Result kinds
  localparam logic KIND_REPLY   = 1'b0;
  localparam logic KIND_FORWARD = 1'b1;

  // Message length rules
  localparam logic [15:0] SCAN_LEN     = 16'd1;
  localparam logic [15:0] LINK_LEN     = 16'd2;
  localparam logic [15:0] SEND_MIN_LEN = 16'd6;

  // Fan-out limit per downstream packet
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned FAN_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int unsigned SESS_W = 16;
  localparam int unsigned DEV_W  = 8;
  localparam int unsigned ENTRY_W = SESS_W + DEV_W;

  // Work class of a captured item
  typedef enum logic [2:0] {
    OP_REPLY,
    OP_LINK,
    OP_SEND,
    OP_CLOSE,
    OP_FANOUT,
    OP_DROP
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EVAL,
    ST_REPLY,
    ST_FLUSH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic clr_scan;
    logic eval;
    logic inc;
    logic emit_reply;
    logic emit_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic cnt_last;
    logic out_free;
    logic fan_stall;
    logic pend_v;
  } status_t;

endpackage

// File: rtl/sdlt_ram.sv
// ----------------------------------------------------------------------------
// sdlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdlt_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/sdlt_ctrl.sv
// ----------------------------------------------------------------------------
// sdlt_ctrl
// Controller: sequences item capture, the slot walk and result emission.
// ----------------------------------------------------------------------------
module sdlt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sdlt_pkg::status_t sts,
  output sdlt_pkg::cmd_t    cmd
);

  sdlt_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdlt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      sdlt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = sdlt_pkg::ST_DECODE;
        end
      end
      sdlt_pkg::ST_DECODE: begin
        case (sts.op)
          sdlt_pkg::OP_REPLY: state_nxt = sdlt_pkg::ST_REPLY;
          sdlt_pkg::OP_DROP:  state_nxt = sdlt_pkg::ST_IDLE;
          default: begin
            cmd.clr_scan = 1'b1;
            state_nxt    = sdlt_pkg::ST_READ;
          end
        endcase
      end
      sdlt_pkg::ST_READ: begin
        state_nxt = sdlt_pkg::ST_EVAL;
      end
      sdlt_pkg::ST_EVAL: begin
        // Hold while a forward waits for room in the output register
        if (!sts.fan_stall) begin
          cmd.eval = 1'b1;
          if (sts.cnt_last) begin
            case (sts.op)
              sdlt_pkg::OP_LINK, sdlt_pkg::OP_SEND: state_nxt = sdlt_pkg::ST_REPLY;
              sdlt_pkg::OP_FANOUT: state_nxt = sdlt_pkg::ST_FLUSH;
              default: state_nxt = sdlt_pkg::ST_IDLE;
            endcase
          end else begin
            cmd.inc   = 1'b1;
            state_nxt = sdlt_pkg::ST_READ;
          end
        end
      end
      sdlt_pkg::ST_REPLY: begin
        if (sts.out_free) begin
          cmd.emit_reply = 1'b1;
          state_nxt      = sdlt_pkg::ST_IDLE;
        end
      end
      sdlt_pkg::ST_FLUSH: begin
        // Emit the held forward as the final one, if any match was found
        if (!sts.pend_v) begin
          state_nxt = sdlt_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = sdlt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sdlt_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/sdlt_datapath.sv
// ----------------------------------------------------------------------------
// sdlt_datapath
// Datapath: item register, link table RAM with valid bits, slot walk
// flags, pending forward and the output register.
// ----------------------------------------------------------------------------
module sdlt_datapath #(
  parameter int unsigned LINK_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [47:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  input  sdlt_pkg::cmd_t    cmd,
  output sdlt_pkg::status_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  localparam int unsigned SLOT_W = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LINK_SLOTS - 1);

  // Captured item
  logic [1:0]                  func_r;
  logic [sdlt_pkg::SESS_W-1:0] sess_r;
  logic [15:0]                 len_r;
  logic [7:0]                  cmd_byte_r;
  logic [sdlt_pkg::DEV_W-1:0]  dev_r;

  // Walk state
  logic [SLOT_W-1:0]              cnt_r;
  logic                           found_r;
  logic                           free_found_r;
  logic [SLOT_W-1:0]              free_idx_r;
  logic [LINK_SLOTS-1:0]          valid_r;
  logic                           pend_v_r;
  logic [sdlt_pkg::SESS_W-1:0]    pend_sess_r;
  logic [sdlt_pkg::FAN_CNT_W-1:0] fan_cnt_r;

  // Output register
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [2:0]                  out_code_r;
  logic [1:0]                  out_act_r;
  logic [sdlt_pkg::SESS_W-1:0] out_sess_r;
  logic [sdlt_pkg::DEV_W-1:0]  out_dev_r;
  logic                        out_last_r;

  // Table RAM
  logic                         ram_we;
  logic [sdlt_pkg::ENTRY_W-1:0] ram_rd;
  logic [sdlt_pkg::SESS_W-1:0]  rd_sess;
  logic [sdlt_pkg::DEV_W-1:0]   rd_dev;

  sdlt_pkg::op_t op;
  logic [2:0]    rep_code;
  logic [1:0]    rep_act;
  logic [7:0]    rep_dev;
  logic          occ;
  logic          sess_hit;
  logic          dev_hit;
  logic          fan_match;
  logic          out_free;

  sdlt_ram #(
    .WIDTH (sdlt_pkg::ENTRY_W),
    .DEPTH (LINK_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (free_idx_r),
    .wr_data ({dev_r, sess_r}),
    .rd_addr (cnt_r),
    .rd_data (ram_rd)
  );

  assign rd_sess   = ram_rd[sdlt_pkg::SESS_W-1:0];
  assign rd_dev    = ram_rd[sdlt_pkg::ENTRY_W-1:sdlt_pkg::SESS_W];
  assign occ       = valid_r[cnt_r];
  assign sess_hit  = occ && (rd_sess == sess_r);
  assign dev_hit   = occ && (rd_dev == dev_r);
  assign fan_match = dev_hit && (fan_cnt_r != sdlt_pkg::FAN_CNT_W'(sdlt_pkg::MAX_RESULTS));
  assign out_free  = !out_valid_r || out_tready;
  assign ram_we    = cmd.emit_reply && (op == sdlt_pkg::OP_LINK) && !found_r && free_found_r;

  // Classify the captured item and form its reply
  always_comb begin
    op       = sdlt_pkg::OP_DROP;
    rep_code = sdlt_pkg::RC_INVALID;
    rep_act  = sdlt_pkg::ACT_NONE;
    rep_dev  = dev_r;
    case (func_r)
      sdlt_pkg::FUNC_MSG: begin
        op = sdlt_pkg::OP_REPLY;
        if (len_r == '0) begin
          rep_dev = '0;
        end else begin
          case (cmd_byte_r)
            sdlt_pkg::CMD_SCAN: begin
              rep_dev = '0;
              if (len_r == sdlt_pkg::SCAN_LEN) begin
                rep_code = sdlt_pkg::RC_OK;
                rep_act  = sdlt_pkg::ACT_SCAN;
              end
            end
            sdlt_pkg::CMD_LINK: begin
              if (len_r == sdlt_pkg::LINK_LEN) begin
                if (sess_r == '0) begin
                  rep_code = sdlt_pkg::RC_ERROR;
                end else begin
                  op       = sdlt_pkg::OP_LINK;
                  rep_code = (!found_r && free_found_r) ? sdlt_pkg::RC_ACK
                                                        : sdlt_pkg::RC_ERROR;
                end
              end
            end
            sdlt_pkg::CMD_SEND: begin
              if (len_r >= sdlt_pkg::SEND_MIN_LEN) begin
                op       = sdlt_pkg::OP_SEND;
                rep_code = found_r ? sdlt_pkg::RC_OK : sdlt_pkg::RC_ERROR;
                rep_act  = found_r ? sdlt_pkg::ACT_FORWARD : sdlt_pkg::ACT_NONE;
              end
            end
            default: begin
              rep_dev  = '0;
              rep_code = sdlt_pkg::RC_UNKNOWN;
            end
          endcase
        end
      end
      sdlt_pkg::FUNC_CLOSE: op = (sess_r == '0) ? sdlt_pkg::OP_DROP : sdlt_pkg::OP_CLOSE;
      sdlt_pkg::FUNC_PKT:   op = sdlt_pkg::OP_FANOUT;
      default:              op = sdlt_pkg::OP_DROP;
    endcase
  end

  // Status to the controller
  always_comb begin
    sts.op        = op;
    sts.cnt_last  = (cnt_r == SLOT_LAST);
    sts.out_free  = out_free;
    sts.fan_stall = (op == sdlt_pkg::OP_FANOUT) && fan_match && pend_v_r && !out_free;
    sts.pend_v    = pend_v_r;
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sess_r     <= in_tdata[15:0];
      len_r      <= in_tdata[31:16];
      cmd_byte_r <= in_tdata[39:32];
      dev_r      <= in_tdata[47:40];
      func_r     <= in_tuser;
    end
  end

  // Walk the slots: counter, flags, valid bits and pending forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      valid_r      <= '0;
      pend_v_r     <= 1'b0;
      fan_cnt_r    <= '0;
    end else begin
      if (cmd.clr_scan) begin
        cnt_r        <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        pend_v_r     <= 1'b0;
        fan_cnt_r    <= '0;
      end
      if (cmd.inc) begin
        cnt_r <= cnt_r + SLOT_W'(1);
      end
      if (cmd.eval) begin
        case (op)
          sdlt_pkg::OP_LINK: begin
            if (sess_hit) begin
              found_r <= 1'b1;
            end
            if (!occ && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= cnt_r;
            end
          end
          sdlt_pkg::OP_SEND: begin
            if (sess_hit && dev_hit) begin
              found_r <= 1'b1;
            end
          end
          sdlt_pkg::OP_CLOSE: begin
            if (sess_hit) begin
              valid_r[cnt_r] <= 1'b0;
            end
          end
          sdlt_pkg::OP_FANOUT: begin
            if (fan_match) begin
              pend_v_r    <= 1'b1;
              pend_sess_r <= rd_sess;
              fan_cnt_r   <= fan_cnt_r + sdlt_pkg::FAN_CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.emit_last) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_reply || cmd.emit_last ||
                 (cmd.eval && (op == sdlt_pkg::OP_FANOUT) && fan_match && pend_v_r)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_reply) begin
      out_kind_r <= sdlt_pkg::KIND_REPLY;
      out_code_r <= rep_code;
      out_act_r  <= rep_act;
      out_sess_r <= sess_r;
      out_dev_r  <= rep_dev;
      out_last_r <= 1'b1;
    end else if (cmd.emit_last ||
                 (cmd.eval && (op == sdlt_pkg::OP_FANOUT) && fan_match && pend_v_r)) begin
      out_kind_r <= sdlt_pkg::KIND_FORWARD;
      out_code_r <= sdlt_pkg::RC_OK;
      out_act_r  <= sdlt_pkg::ACT_NONE;
      out_sess_r <= pend_sess_r;
      out_dev_r  <= dev_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_dev_r, out_sess_r, out_act_r, out_code_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/session_device_link_table_top.sv
// ----------------------------------------------------------------------------
// session_device_link_table_top
// Session/device link table: command replies, session close and packet
// fan-out to linked sessions.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_*     slave      tuser: func; tdata: session, msg_len, cmd_byte, device_num
//  out_*    master     tuser: kind; tdata: reply_code, action, target_session,
//                      target_device; tlast: last
//
//  Flow: a message answered without a table walk goes from decode to the reply;
//  an ignored item or a close of session zero returns to idle after decode;
//  link, send, packet and close items walk every slot through the table RAM read
//  port, a read state then an eval state per slot; one item is taken at a time.
//  Reset: synchronous, active low; clears all valid bits, so the table is
//  empty at once with no clearing pass.
//  Stalls: a held output stalls the walk when a further forward is due, and
//  holds a reply or the final forward until the output register frees.
// ----------------------------------------------------------------------------
module session_device_link_table_top #(
  parameter int unsigned LINK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // session[15:0], msg_len[31:16], cmd_byte[39:32],
                                  // device_num[47:40]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // reply_code[2:0], action[4:3],
                                  // target_session[20:5], target_device[28:21]
  output logic        out_tuser,  // kind[0]
  output logic        out_tlast
);

  sdlt_pkg::cmd_t    cmd;
  sdlt_pkg::status_t sts;

  sdlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdlt_datapath #(
    .LINK_SLOTS (LINK_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: test/link_table_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_table_check_pkg
// Link table predictor and expected-result store for the session/device link
// table testbench: mirrors the slot table, turns each accepted input
// transaction into the replies or forwards it should cause, and compares
// them field by field against the result stream.
// ----------------------------------------------------------------------------
package link_table_check_pkg;
  import sdlt_pkg::*;

  localparam int unsigned TBL_SLOTS = 8;

  // Selector value the block ignores
  localparam logic [1:0] FUNC_IDLE = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [2:0]  code;
    logic [1:0]  action;
    logic [15:0] sess;
    logic [7:0]  dev;
    logic        last;
  } link_result_t;

  class link_table_model;
    logic [15:0]  slot_sess [TBL_SLOTS];
    logic [7:0]   slot_dev [TBL_SLOTS];
    link_result_t due_results [$];
    int unsigned  errors;
    int unsigned  items;
    int unsigned  results;
    int unsigned  forwards;
    int unsigned  acks;

    function new();
      foreach (slot_sess[i]) begin
        slot_sess[i] = '0;
        slot_dev[i]  = '0;
      end
      errors   = 0;
      items    = 0;
      results  = 0;
      forwards = 0;
      acks     = 0;
    endfunction

    // Reject a session already present, else take the first free slot
    function logic [2:0] bind_session(logic [15:0] sess, logic [7:0] dev);
      foreach (slot_sess[i]) begin
        if (slot_sess[i] == sess) return RC_ERROR;
      end
      foreach (slot_sess[i]) begin
        if (slot_sess[i] == '0) begin
          slot_sess[i] = sess;
          slot_dev[i]  = dev;
          return RC_ACK;
        end
      end
      return RC_ERROR;
    endfunction

    function bit has_link(logic [15:0] sess, logic [7:0] dev);
      foreach (slot_sess[i]) begin
        if (slot_sess[i] != '0 && slot_sess[i] == sess && slot_dev[i] == dev) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Predict the results of one accepted input transaction
    function void note_item(logic [1:0] func, logic [15:0] sess, logic [15:0] len,
                            logic [7:0] cmd, logic [7:0] dev);
      link_result_t res;
      int unsigned  n;
      items++;
      res        = '0;
      res.kind   = KIND_REPLY;
      res.action = ACT_NONE;
      res.sess   = sess;
      res.last   = 1'b1;
      n          = 0;
      case (func)
        FUNC_MSG: begin
          if (len == '0) begin
            res.code = RC_INVALID;
          end else if (cmd == CMD_SCAN) begin
            if (len != SCAN_LEN) begin
              res.code = RC_INVALID;
            end else begin
              res.code   = RC_OK;
              res.action = ACT_SCAN;
            end
          end else if (cmd == CMD_LINK) begin
            res.dev  = dev;
            res.code = (len != LINK_LEN) ? RC_INVALID : bind_session(sess, dev);
          end else if (cmd == CMD_SEND) begin
            res.dev = dev;
            if (len < SEND_MIN_LEN) begin
              res.code = RC_INVALID;
            end else if (!has_link(sess, dev)) begin
              res.code = RC_ERROR;
            end else begin
              res.code   = RC_OK;
              res.action = ACT_FORWARD;
            end
          end else begin
            res.code = RC_UNKNOWN;
          end
          if (res.code == RC_ACK) acks++;
          due_results.push_back(res);
        end
        FUNC_CLOSE: begin
          // Session zero marks free slots and never closes anything
          if (sess != '0) begin
            foreach (slot_sess[i]) begin
              if (slot_sess[i] == sess) begin
                slot_sess[i] = '0;
                slot_dev[i]  = '0;
              end
            end
          end
        end
        FUNC_PKT: begin
          // Fan out one forward per linked slot in slot order, mark the final one
          foreach (slot_sess[i]) begin
            if (slot_sess[i] != '0 && slot_dev[i] == dev && n < MAX_RESULTS) begin
              res      = '0;
              res.kind = KIND_FORWARD;
              res.code = RC_OK;
              res.sess = slot_sess[i];
              res.dev  = dev;
              due_results.push_back(res);
              n++;
            end
          end
          if (n > 0) begin
            res      = due_results.pop_back();
            res.last = 1'b1;
            due_results.push_back(res);
          end
        end
        default: begin
          // Unused selector: drop without effect
        end
      endcase
    endfunction

    function void chk_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result transaction with the oldest prediction
    function void check_result(logic [31:0] data, logic kind, logic last);
      link_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b tlast=%b",
                 $time, data, kind, last);
        return;
      end
      want = due_results.pop_front();
      results++;
      if (want.kind == KIND_FORWARD) forwards++;
      chk_field("kind", want.kind, kind);
      chk_field("reply_code", want.code, data[2:0]);
      chk_field("action", want.action, data[4:3]);
      chk_field("target_session", want.sess, data[20:5]);
      chk_field("target_device", want.dev, data[28:21]);
      chk_field("last", want.last, last);
    endfunction
  endclass

endpackage

// File: test/session_device_link_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_device_link_table_top_tb
// Drives command messages, session closes and downstream packets into the
// link table with random gaps on both streams, predicts every reply and
// forward, and checks the result stream in order.
// ----------------------------------------------------------------------------
module session_device_link_table_top_tb;
  import sdlt_pkg::*;
  import link_table_check_pkg::*;

  localparam int unsigned ITEM_TARGET = 375;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4 * TBL_SLOTS + 12;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // session[15:0], msg_len[31:16], cmd_byte[39:32],
                           // device_num[47:40]
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // reply_code[2:0], action[4:3], target_session[20:5],
                           // target_device[28:21]
  logic        out_tuser;  // kind[0]
  logic        out_tlast;

  link_table_model link_tbl = new();
  logic [15:0]     sess_pool [12];
  logic [7:0]      dev_pool [4];
  bit              tx_burst;
  int unsigned     idle_cycles;

  session_device_link_table_top #(
    .LINK_SLOTS(TBL_SLOTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort when no transaction moves on either stream for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("session_device_link_table_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) link_tbl.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Result sink: random stalls with occasional always-ready stretches
  initial begin
    int unsigned n;
    int unsigned seen;
    bit          rx_burst;
    out_tready = 1'b0;
    rx_burst   = 1'b0;
    seen       = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seen % 30 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      n = rx_burst ? 0 : $urandom_range(0, 14);
      if (n != 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      seen++;
    end
  end

  function automatic logic [15:0] pick_sess();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return sess_pool[$urandom_range(0, 11)];
    if (r < 95) return 16'($urandom_range(0, 65535));
    return '0;
  endfunction

  function automatic logic [7:0] pick_dev();
    if ($urandom_range(0, 99) < 85) return dev_pool[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one input transaction after a random gap and wait for acceptance
  task automatic send_item(logic [1:0] func, logic [15:0] sess, logic [15:0] len,
                           logic [7:0] cmd, logic [7:0] dev);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {dev, cmd, len, sess};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    link_tbl.note_item(func, sess, len, cmd, dev);
  endtask

  // Hold the input until every predicted result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (link_tbl.due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned count;
    int unsigned r;
    int unsigned k;
    bit          drained;
    logic [15:0] s;
    logic [15:0] l;
    logic [7:0]  c;
    logic [7:0]  d;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_MSG;
    tx_burst  = 1'b0;
    drained   = 1'b0;
    foreach (sess_pool[i]) sess_pool[i] = 16'($urandom_range(1, 65535));
    foreach (dev_pool[i]) dev_pool[i] = 8'($urandom_range(0, 255));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, length rules, unknown commands
    send_item(FUNC_PKT, 16'h0000, 16'h0000, 8'h00, 8'h00);
    send_item(FUNC_MSG, 16'h1234, 16'h0000, CMD_LINK, 8'h77);
    send_item(FUNC_MSG, 16'h0001, SCAN_LEN, CMD_SCAN, 8'h00);
    send_item(FUNC_MSG, 16'h0001, LINK_LEN, CMD_SCAN, 8'h00);
    send_item(FUNC_MSG, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    // Link, duplicate link, bad length, session zero
    send_item(FUNC_MSG, 16'hFFFF, LINK_LEN, CMD_LINK, 8'hFF);
    send_item(FUNC_MSG, 16'hFFFF, LINK_LEN, CMD_LINK, 8'h01);
    send_item(FUNC_MSG, 16'h0002, 16'd3, CMD_LINK, 8'h01);
    send_item(FUNC_MSG, 16'h0000, LINK_LEN, CMD_LINK, 8'h01);
    // Send: short, minimum length, wrong device, session zero
    send_item(FUNC_MSG, 16'hFFFF, 16'd5, CMD_SEND, 8'hFF);
    send_item(FUNC_MSG, 16'hFFFF, SEND_MIN_LEN, CMD_SEND, 8'hFF);
    send_item(FUNC_MSG, 16'hFFFF, 16'hFFFF, CMD_SEND, 8'hFE);
    send_item(FUNC_MSG, 16'h0000, 16'd6, CMD_SEND, 8'h00);
    send_item(FUNC_PKT, 16'h0000, 16'h0000, 8'h00, 8'hFF);
    // Ignored selector, close of session zero, real close
    send_item(FUNC_IDLE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(FUNC_CLOSE, 16'h0000, 16'h0000, 8'h00, 8'h00);
    send_item(FUNC_CLOSE, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
    // Fill the table on one device, overflow it, then full fan-out
    for (k = 1; k <= TBL_SLOTS; k++) begin
      send_item(FUNC_MSG, 16'(16'h1000 + k), LINK_LEN, CMD_LINK, 8'h5A);
    end
    send_item(FUNC_MSG, 16'h2000, LINK_LEN, CMD_LINK, 8'h5A);
    send_item(FUNC_PKT, 16'h0000, 16'h0000, 8'h00, 8'h5A);
    send_item(FUNC_CLOSE, 16'h1003, 16'h0000, 8'h00, 8'h00);

    // Random: mostly well-formed link/send/close/packet traffic
    count = 0;
    while (count < ITEM_TARGET) begin
      if (count % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (count == ITEM_TARGET / 2 && !drained) begin
        drain_results();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      k = $urandom_range(0, TBL_SLOTS - 1);
      s = pick_sess();
      d = pick_dev();
      l = 16'($urandom_range(0, 65535));
      c = 8'($urandom_range(3, 255));
      if (r < 25) begin
        if ($urandom_range(0, 9) != 0) l = LINK_LEN;
        send_item(FUNC_MSG, s, l, CMD_LINK, d);
      end else if (r < 45) begin
        if ($urandom_range(0, 4) != 0 && link_tbl.slot_sess[k] != '0) begin
          s = link_tbl.slot_sess[k];
          d = link_tbl.slot_dev[k];
        end
        r = $urandom_range(0, 99);
        if (r < 15) l = 16'($urandom_range(0, 5));
        else if (r < 80) l = 16'($urandom_range(6, 64));
        else l = 16'($urandom_range(6, 65535));
        send_item(FUNC_MSG, s, l, CMD_SEND, d);
      end else if (r < 65) begin
        if ($urandom_range(0, 4) != 0 && link_tbl.slot_sess[k] != '0) d = link_tbl.slot_dev[k];
        send_item(FUNC_PKT, 16'($urandom_range(0, 65535)), l, c, d);
      end else if (r < 77) begin
        if ($urandom_range(0, 9) < 7 && link_tbl.slot_sess[k] != '0) s = link_tbl.slot_sess[k];
        send_item(FUNC_CLOSE, s, l, c, d);
      end else if (r < 85) begin
        if ($urandom_range(0, 4) != 0) l = SCAN_LEN;
        send_item(FUNC_MSG, s, l, CMD_SCAN, d);
      end else if (r < 95) begin
        send_item(FUNC_MSG, s, l, c, d);
      end else begin
        // Ignored selector: does not count toward the item total
        send_item(FUNC_IDLE, s, l, c, d);
        count--;
      end
      count++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d input transactions: %0d results, %0d forwards, %0d links bound.",
             link_tbl.items, link_tbl.results, link_tbl.forwards, link_tbl.acks);
    if (link_tbl.errors == 0) begin
      $display("session_device_link_table_top_tb: done, clean");
    end else begin
      $display("session_device_link_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: session_device_link_table_top.f
rtl/sdlt_pkg.sv
rtl/sdlt_ram.sv
rtl/sdlt_ctrl.sv
rtl/sdlt_datapath.sv
rtl/session_device_link_table_top.sv
test/link_table_check_pkg.sv
test/session_device_link_table_top_tb.sv
